FILE: rtl/pbd_pkg.sv
// Shared constants, types and state encodings for the PackBits decoder.
`default_nettype none
package pbd_pkg;
	localparam int LANES     = 8;
	localparam int LEN_BITS  = 24;
	localparam int LIMIT_W   = 24;
	localparam int DATA_W    = 64;
	localparam int COUNT_W   = 4;
	localparam int BYTE_W    = 8;
	localparam int LIT_DEPTH = 128;
	localparam int ROWS      = (LIT_DEPTH + LANES - 1) / LANES;
	localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int CMP_W     = ((LEN_BITS > LIMIT_W) ? LEN_BITS : LIMIT_W) + 1;

	localparam logic [BYTE_W-1:0]  HDR_SKIP    = 8'h80;
	localparam logic [BYTE_W:0]    REP_BASE    = 9'd257;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'hFF_FFFF;
	localparam logic               KIND_DATA   = 1'b0;
	localparam logic               KIND_STATUS = 1'b1;

	typedef logic [BYTE_W-1:0]             byte_t;
	typedef logic [ROW_W-1:0]              row_t;
	typedef logic [LANE_W-1:0]             lane_t;
	typedef logic [LANES-1:0][BYTE_W-1:0]  lane_vec_t;
	typedef logic [LEN_BITS-1:0]           len_t;
	typedef logic [LIMIT_W-1:0]            limit_t;
	typedef logic [COUNT_W-1:0]            count_t;
	typedef logic [CMP_W-1:0]              cmp_t;

	typedef enum logic [1:0] {
		PH_HDR,
		PH_LIT,
		PH_REP,
		PH_DRAIN
	} phase_t;

	typedef enum logic [1:0] {
		SQ_IN,
		SQ_EMIT,
		SQ_STAT
	} seq_t;

	typedef struct packed {
		byte_t total;
		logic  lit;
		byte_t rep;
	} run_cmd_t;

	typedef struct packed {
		lane_vec_t data;
		count_t    cnt;
		logic      run_end;
	} beat_t;
endpackage
`default_nettype wire

FILE: rtl/pbd_in_if.sv
// Compressed byte input channel.
`default_nettype none
interface pbd_in_if import pbd_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t in_byte;
	logic  in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/pbd_out_if.sv
// Decoded beat and status output channel.
`default_nettype none
interface pbd_out_if import pbd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                out_kind;
	logic [DATA_W-1:0]   out_data;
	count_t              out_count;
	logic                out_run_end;
	logic                out_error;
	limit_t              out_length;

	modport source (output valid, output out_kind, output out_data, output out_count,
		output out_run_end, output out_error, output out_length, input ready);
	modport sink (input valid, input out_kind, input out_data, input out_count,
		input out_run_end, input out_error, input out_length, output ready);
endinterface
`default_nettype wire

FILE: rtl/pbd_cfg_if.sv
// Output limit register write channel.
`default_nettype none
interface pbd_cfg_if import pbd_pkg::*; ();
	logic   valid;
	logic   ready;
	limit_t out_limit;

	modport source (output valid, output out_limit, input ready);
	modport sink (input valid, input out_limit, output ready);
endinterface
`default_nettype wire

FILE: rtl/pbd_lit_buf.sv
// Literal buffer: byte-lane write, one row read per cycle, registered read data.
`default_nettype none
module pbd_lit_buf import pbd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_clr,
	input  wire logic      wr_en,
	input  wire byte_t     wr_byte,
	input  wire row_t      rd_row,
	output lane_vec_t      rd_data
);
	lane_vec_t mem [ROWS];
	row_t      wr_row_q;
	lane_t     wr_lane_q;
	lane_vec_t rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_row_q  <= '0;
			wr_lane_q <= '0;
		end else if (wr_clr) begin
			wr_row_q  <= '0;
			wr_lane_q <= '0;
		end else if (wr_en) begin
			if (wr_lane_q == lane_t'(LANES - 1)) begin
				wr_lane_q <= '0;
				wr_row_q  <= wr_row_q + row_t'(1);
			end else begin
				wr_lane_q <= wr_lane_q + lane_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row_q][wr_lane_q] <= wr_byte;
		end
		rd_data_q <= mem[rd_row];
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

FILE: rtl/pbd_beat_gen.sv
// Beat generator: counts a run down by up to LANES bytes per beat.
`default_nettype none
module pbd_beat_gen import pbd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire run_cmd_t  cmd,
	input  wire logic      adv,
	input  wire lane_vec_t rd_data,
	output row_t           rd_row,
	output beat_t          beat,
	output logic           beat_valid,
	output logic           busy
);
	byte_t  rem_q;
	logic   lit_q;
	byte_t  rep_q;
	row_t   row_q;
	logic   rd_ok_q;
	count_t cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			row_q   <= '0;
			rd_ok_q <= 1'b0;
		end else if (start) begin
			rem_q   <= cmd.total;
			row_q   <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= busy;
			if (adv) begin
				rem_q <= rem_q - byte_t'(cnt);
				row_q <= row_q + row_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			lit_q <= cmd.lit;
			rep_q <= cmd.rep;
		end
	end

	always_comb begin
		busy       = (rem_q != '0);
		beat_valid = busy && rd_ok_q;
		cnt        = (rem_q > byte_t'(LANES)) ? count_t'(LANES) : count_t'(rem_q);
		rd_row     = adv ? (row_q + row_t'(1)) : row_q;
		beat.cnt     = cnt;
		beat.run_end = (rem_q <= byte_t'(LANES));
		for (int i = 0; i < LANES; i++) begin
			if (count_t'(i) < cnt) begin
				beat.data[i] = lit_q ? rd_data[i] : rep_q;
			end else begin
				beat.data[i] = '0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/packbits_decoder.sv
// PackBits decoder top level: header parsing, sequencer and output register.
// Takes one compressed byte per cycle while no run or status beat is being emitted.
// A byte that completes a literal or carries a repeat value starts a run; the block
// then stops taking input while the single beat generator reads the first row and
// sends output beats of up to 8 bytes (ceil(n/8) beats for an n-byte run), walking
// the literal buffer one row per cycle while the output is free. A final byte adds
// a status beat. The output register lets an item be accepted while a beat still waits.
`default_nettype none
module packbits_decoder import pbd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	pbd_cfg_if.sink   cfg,
	pbd_in_if.sink    din,
	pbd_out_if.source dout
);
	limit_t    limit_q;
	phase_t    phase_q, phase_d;
	byte_t     run_left_q, run_left_d;
	byte_t     fill_q, fill_d;
	len_t      produced_q, produced_d;
	logic      failed_q, failed_d;
	seq_t      seq_q, seq_d;
	logic      stat_pend_q;
	logic      stat_err_q;
	limit_t    stat_len_q;

	logic      in_acc;
	logic      hdr_lit;
	byte_t     run_len;
	logic      at_limit;
	logic      over;
	byte_t     fill_inc;
	logic      lit_wr;
	logic      lit_clr;
	logic      run_start;
	run_cmd_t  run_cmd;
	logic      stat_go;
	logic      stat_err;
	limit_t    stat_len;

	logic      out_free;
	logic      beat_take;
	logic      stat_take;
	row_t      rd_row;
	lane_vec_t rd_data;
	beat_t     beat;
	logic      beat_valid;
	logic      gen_busy;

	logic                ov_q;
	logic                kind_q;
	logic [DATA_W-1:0]   data_q;
	count_t              count_q;
	logic                run_end_q;
	logic                err_q;
	limit_t              len_q;

	pbd_lit_buf u_lit_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_clr  (lit_clr),
		.wr_en   (lit_wr),
		.wr_byte (din.in_byte),
		.rd_row  (rd_row),
		.rd_data (rd_data)
	);

	pbd_beat_gen u_beat_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (run_start),
		.cmd        (run_cmd),
		.adv        (beat_take),
		.rd_data    (rd_data),
		.rd_row     (rd_row),
		.beat       (beat),
		.beat_valid (beat_valid),
		.busy       (gen_busy)
	);

	assign cfg.ready = 1'b1;
	assign in_acc    = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			limit_q <= cfg.out_limit;
		end
	end

	// header decode
	always_comb begin
		hdr_lit  = !din.in_byte[BYTE_W-1];
		run_len  = hdr_lit ? (din.in_byte + byte_t'(1))
			: byte_t'(REP_BASE - {1'b0, din.in_byte});
		at_limit = cmp_t'(produced_q) >= cmp_t'(limit_q);
		over     = (cmp_t'(produced_q) + cmp_t'(run_len)) > cmp_t'(limit_q);
		fill_inc = fill_q + byte_t'(1);
	end

	// stream state update
	always_comb begin
		phase_d    = phase_q;
		run_left_d = run_left_q;
		fill_d     = fill_q;
		produced_d = produced_q;
		failed_d   = failed_q;
		lit_wr     = 1'b0;
		lit_clr    = 1'b0;
		run_start  = 1'b0;
		run_cmd.total = run_left_q;
		run_cmd.lit   = 1'b0;
		run_cmd.rep   = din.in_byte;
		stat_go    = 1'b0;
		stat_err   = 1'b0;
		stat_len   = '0;
		if (in_acc) begin
			unique case (phase_q)
				PH_HDR: begin
					if (!at_limit && din.in_byte != HDR_SKIP) begin
						run_left_d = run_len;
						if (over) begin
							failed_d = 1'b1;
							phase_d  = PH_DRAIN;
						end else begin
							fill_d  = '0;
							lit_clr = 1'b1;
							phase_d = hdr_lit ? PH_LIT : PH_REP;
						end
					end
				end
				PH_LIT: begin
					lit_wr = 1'b1;
					fill_d = fill_inc;
					if (fill_inc >= run_left_q) begin
						run_start   = 1'b1;
						run_cmd.lit = 1'b1;
						fill_d      = '0;
						phase_d     = PH_HDR;
						produced_d  = produced_q + len_t'(run_left_q);
					end
				end
				PH_REP: begin
					run_start  = 1'b1;
					phase_d    = PH_HDR;
					produced_d = produced_q + len_t'(run_left_q);
				end
				PH_DRAIN: begin
				end
			endcase
			if (din.in_last) begin
				stat_go    = 1'b1;
				stat_err   = failed_d || phase_d == PH_LIT || phase_d == PH_REP;
				stat_len   = stat_err ? '0 : limit_t'(produced_d);
				phase_d    = PH_HDR;
				run_left_d = '0;
				fill_d     = '0;
				produced_d = '0;
				failed_d   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR;
			run_left_q  <= '0;
			fill_q      <= '0;
			produced_q  <= '0;
			failed_q    <= 1'b0;
			seq_q       <= SQ_IN;
			stat_pend_q <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			run_left_q <= run_left_d;
			fill_q     <= fill_d;
			produced_q <= produced_d;
			failed_q   <= failed_d;
			seq_q      <= seq_d;
			if (stat_go) begin
				stat_pend_q <= 1'b1;
			end else if (stat_take) begin
				stat_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat_go) begin
			stat_err_q <= stat_err;
			stat_len_q <= stat_len;
		end
	end

	// sequencer next state
	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			SQ_IN: begin
				if (run_start) begin
					seq_d = SQ_EMIT;
				end else if (stat_go) begin
					seq_d = SQ_STAT;
				end
			end
			SQ_EMIT: begin
				if (beat_take && beat.run_end) begin
					seq_d = stat_pend_q ? SQ_STAT : SQ_IN;
				end
			end
			SQ_STAT: begin
				if (out_free) begin
					seq_d = SQ_IN;
				end
			end
			default: seq_d = SQ_IN;
		endcase
	end

	// sequencer outputs
	always_comb begin
		out_free  = !ov_q || dout.ready;
		din.ready = (seq_q == SQ_IN);
		beat_take = (seq_q == SQ_EMIT) && beat_valid && out_free;
		stat_take = (seq_q == SQ_STAT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_free) begin
			ov_q <= beat_take || stat_take;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_take) begin
			kind_q    <= KIND_DATA;
			data_q    <= DATA_W'(beat.data);
			count_q   <= beat.cnt;
			run_end_q <= beat.run_end;
			err_q     <= 1'b0;
			len_q     <= '0;
		end else if (stat_take) begin
			kind_q    <= KIND_STATUS;
			data_q    <= '0;
			count_q   <= '0;
			run_end_q <= 1'b0;
			err_q     <= stat_err_q;
			len_q     <= stat_err_q ? '0 : stat_len_q;
		end
	end

	assign dout.valid       = ov_q;
	assign dout.out_kind    = kind_q;
	assign dout.out_data    = data_q;
	assign dout.out_count   = count_q;
	assign dout.out_run_end = run_end_q;
	assign dout.out_error   = err_q;
	assign dout.out_length  = len_q;

`ifndef SYNTH
	a_beat_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && kind_q == KIND_DATA) |-> (count_q != '0 && count_q <= count_t'(LANES)))
		else $error("data beat lane count out of range");

	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && kind_q == KIND_STATUS && err_q) |-> (len_q == '0))
		else $error("error status with nonzero length");

	a_gen_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		gen_busy |-> (seq_q == SQ_EMIT))
		else $error("beat generator busy outside emit");

	a_stat_done: assert property (@(posedge clk) disable iff (!arst_n)
		stat_take |=> (seq_q == SQ_IN && !stat_pend_q))
		else $error("status beat did not return sequencer to input");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= run_left_q)
		else $error("literal fill past run length");
`endif
endmodule
`default_nettype wire

FILE: tb/packbits_decoder_tb.sv
// Self-checking testbench for the PackBits decoder: random streams, limits and flow control.
`timescale 1ns / 100ps
module packbits_decoder_tb import pbd_pkg::*; ();

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LIVE_TARGET = 150;
	localparam int HOLD_AT     = 80;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic              kind;
		logic [DATA_W-1:0] data;
		count_t            count;
		logic              run_end;
		logic              err;
		limit_t            length;
	} beat_rec_t;

	class pbd_decode_checker;
		limit_t    limit;
		phase_t    ph;
		int        run_len;
		byte_t     lit_buf[LIT_DEPTH];
		int        lit_fill;
		len_t      produced;
		logic      failed;
		beat_rec_t beats_due[$];
		int        errors;

		function new();
			limit  = LIMIT_RESET;
			errors = 0;
			restart();
		endfunction

		function void restart();
			ph       = PH_HDR;
			run_len  = 0;
			lit_fill = 0;
			produced = '0;
			failed   = 1'b0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		function void queue_run(int n, bit from_lit, byte_t val);
			beat_rec_t r;
			int pos;
			int cnt;
			pos = 0;
			while (pos < n) begin
				cnt = (n - pos > LANES) ? LANES : n - pos;
				r = '0;
				r.kind  = KIND_DATA;
				r.count = count_t'(cnt);
				for (int i = 0; i < cnt; i++)
					r.data[8*i +: 8] = from_lit ? lit_buf[(pos + i) % LIT_DEPTH] : val;
				pos += cnt;
				r.run_end = (pos == n);
				beats_due.push_back(r);
			end
			produced = len_t'(int'(produced) + n);
		endfunction

		// returns 1 when the byte did something other than being dropped
		function bit take_byte(byte_t b, logic last);
			beat_rec_t r;
			bit live;
			live = 1'b1;
			case (ph)
				PH_HDR: begin
					if (int'(produced) >= int'(limit)) begin
						live = 1'b0;
					end else if (b != HDR_SKIP) begin
						run_len = (b < HDR_SKIP) ? int'(b) + 1 : int'(REP_BASE) - int'(b);
						if (int'(produced) + run_len > int'(limit)) begin
							failed = 1'b1;
							ph     = PH_DRAIN;
						end else begin
							lit_fill = 0;
							ph       = (b < HDR_SKIP) ? PH_LIT : PH_REP;
						end
					end
				end
				PH_LIT: begin
					lit_buf[lit_fill % LIT_DEPTH] = b;
					lit_fill++;
					if (lit_fill >= run_len) begin
						queue_run(run_len, 1'b1, '0);
						lit_fill = 0;
						ph       = PH_HDR;
					end
				end
				PH_REP: begin
					queue_run(run_len, 1'b0, b);
					ph = PH_HDR;
				end
				default: live = 1'b0;
			endcase
			if (last) begin
				if (ph == PH_LIT || ph == PH_REP)
					failed = 1'b1;
				r = '0;
				r.kind   = KIND_STATUS;
				r.err    = failed;
				r.length = failed ? '0 : limit_t'(produced);
				beats_due.push_back(r);
				restart();
				live = 1'b1;
			end
			return live;
		endfunction

		task match_beat(beat_rec_t got);
			beat_rec_t want;
			if (beats_due.size() == 0) begin
				report($sformatf("unexpected beat kind=%0d data=%h count=%0d len=%0d",
					got.kind, got.data, got.count, got.length));
				return;
			end
			want = beats_due.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.data !== want.data)
				report($sformatf("data %h, want %h", got.data, want.data));
			if (got.count !== want.count)
				report($sformatf("count %0d, want %0d", got.count, want.count));
			if (got.run_end !== want.run_end)
				report($sformatf("run_end %0d, want %0d", got.run_end, want.run_end));
			if (got.err !== want.err)
				report($sformatf("error %0d, want %0d", got.err, want.err));
			if (got.length !== want.length)
				report($sformatf("length %0d, want %0d", got.length, want.length));
		endtask
	endclass

	logic clk;
	logic arst_n;

	pbd_in_if  in_ch();
	pbd_out_if out_ch();
	pbd_cfg_if cfg_ch();

	packbits_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.din    (in_ch),
		.dout   (out_ch)
	);

	pbd_decode_checker sb = new();

	byte_t stream_q[$];
	int    items_live;
	int    in_free;
	int    out_hold_req;
	bit    hold_done;
	int    cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin : out_mon
		beat_rec_t got;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got.kind    = out_ch.out_kind;
			got.data    = out_ch.out_data;
			got.count   = out_ch.out_count;
			got.run_end = out_ch.out_run_end;
			got.err     = out_ch.out_error;
			got.length  = out_ch.out_length;
			sb.match_beat(got);
		end
	end

	// output side back-pressure
	initial begin : out_sink
		int stall_left;
		int free_left;
		stall_left = 0;
		free_left  = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (out_hold_req > 0) begin
				stall_left   = out_hold_req;
				out_hold_req = 0;
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if (free_left > 0)
					free_left--;
				else if ($urandom_range(0, 99) < 3)
					free_left = $urandom_range(20, 80);
				else if ($urandom_range(0, 3) == 0)
					stall_left = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3)
						: $urandom_range(10, 40);
			end
		end
	end

	function automatic int in_gap();
		int r;
		if (in_free > 0) begin
			in_free--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			in_free = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// mostly well-formed runs; some noise streams and some cut short
	function automatic void make_stream();
		int runs;
		int n;
		int kind;
		stream_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 12);
			repeat (n) stream_q.push_back(byte_t'($urandom_range(0, 255)));
			return;
		end
		runs = $urandom_range(1, 5);
		repeat (runs) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 12);
				stream_q.push_back(byte_t'(n - 1));
				repeat (n) stream_q.push_back(byte_t'($urandom_range(0, 255)));
			end else if (kind < 9) begin
				n = $urandom_range(2, 128);
				stream_q.push_back(byte_t'(257 - n));
				stream_q.push_back(byte_t'($urandom_range(0, 255)));
			end else begin
				stream_q.push_back(HDR_SKIP);
			end
		end
		if ($urandom_range(0, 7) == 0 && stream_q.size() > 1) begin
			n = $urandom_range(1, stream_q.size() - 1);
			repeat (n) void'(stream_q.pop_back());
		end
	endfunction

	task automatic send_byte(input byte_t b, input logic last);
		int gap;
		gap = in_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.in_last <= last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		if (sb.take_byte(b, last))
			items_live++;
		if (!hold_done && items_live >= HOLD_AT) begin
			out_hold_req = HOLD_CYCLES;
			hold_done    = 1'b1;
		end
	endtask

	task automatic drain(input int extra);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.beats_due.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic send_stream(input int pause_at);
		foreach (stream_q[i]) begin
			if (i == pause_at)
				drain(0);
			send_byte(stream_q[i], i == stream_q.size() - 1);
		end
	endtask

	task automatic write_limit(input limit_t v);
		@(negedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.out_limit <= v;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		sb.limit = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		limit_t lim;
		int     n_streams;
		cycles       = 0;
		items_live   = 0;
		in_free      = 0;
		out_hold_req = 0;
		hold_done    = 1'b0;
		arst_n           <= 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.in_byte    <= '0;
		in_ch.in_last    <= 1'b0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.out_limit <= LIMIT_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_limit(LIMIT_RESET);
		// skip, 1-byte literal, shortest and longest repeat, short literal
		stream_q = '{8'h80, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h81, 8'h5A,
			8'h02, 8'h01, 8'h02, 8'h03};
		send_stream(-1);
		// stream ends on a literal header, mid literal, on a repeat header
		stream_q = '{8'h05};
		send_stream(-1);
		stream_q = '{8'h03, 8'h11, 8'h22};
		send_stream(-1);
		stream_q = '{8'hFE};
		send_stream(-1);
		drain(20);
		write_limit(24'd4);
		// run overflows the limit, remainder dropped
		stream_q = '{8'h01, 8'hAA, 8'hBB, 8'hFE, 8'hCC, 8'h00, 8'h77};
		send_stream(-1);
		// limit hit exactly, later headers ignored
		stream_q = '{8'hFD, 8'h99, 8'h7F, 8'h33};
		send_stream(-1);
		drain(20);
		write_limit('0);
		stream_q = '{8'h00, 8'h01};
		send_stream(-1);
		drain(20);
		write_limit(LIMIT_RESET);

		while (items_live < LIVE_TARGET) begin
			n_streams = $urandom_range(1, 3);
			repeat (n_streams) begin
				make_stream();
				send_stream(($urandom_range(0, 5) == 0) ?
					$urandom_range(0, stream_q.size() - 1) : -1);
			end
			drain(20);
			case ($urandom_range(0, 7))
				0:       lim = '0;
				1:       lim = limit_t'($urandom_range(1, 40));
				2:       lim = limit_t'($urandom_range(41, 600));
				3:       lim = limit_t'($urandom_range(0, 24'hFF_FFFF));
				default: lim = LIMIT_RESET;
			endcase
			write_limit(lim);
		end

		drain(50);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
rtl/pbd_pkg.sv
rtl/pbd_in_if.sv
rtl/pbd_out_if.sv
rtl/pbd_cfg_if.sv
rtl/pbd_lit_buf.sv
rtl/pbd_beat_gen.sv
rtl/packbits_decoder.sv
tb/packbits_decoder_tb.sv
